### rtl/anagram_histogram_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the anagram histogram checker
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ANAGRAM_HISTOGRAM_CHECKER_TOP_ASSERT_SVH
`define ANAGRAM_HISTOGRAM_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Implication in the same cycle, checked outside reset.
`define AHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("ahc check failed");
// Implication into the next cycle, checked outside reset.
`define AHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahc check failed");
`else
`define AHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/ahc_pkg.sv
// ----------------------------------------------------------------------------
// Anagram histogram checker package
// Word types and fixed widths shared by the checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ahc_pkg;

    localparam int BYTE_W    = 8;
    localparam int BALANCE_W = 14;
    localparam int COUNT_W   = 9;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic              first_present;
        logic [BYTE_W-1:0] second_byte;
        logic              second_present;
        logic              final_item;
    } t_in_word;

    typedef struct packed {
        logic is_anagram;
        logic length_differs;
    } t_out_word;

    // One counter update as it travels from the issue stage to the update stage.
    typedef struct packed {
        logic valid;       // an update occupies the stage
        logic en;          // the byte is present, so the counter changes
        logic up;          // increment for the first string, decrement for the second
        logic tail;        // second update of the word, carries the flag updates
        logic final_item;  // word closes the pair of strings
        logic mismatch;    // present flags of the word disagree
        logic seen;        // some present flag of the word is set
    } t_op;

endpackage

`default_nettype wire

### rtl/ahc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ahc_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/ahc_fold.sv
// ----------------------------------------------------------------------------
// Byte folding
// Reduces a byte modulo the alphabet size through a constant lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

module ahc_fold #(
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic [ahc_pkg::BYTE_W-1:0]         i_byte,
    output logic      [$clog2(ALPHABET_SIZE)-1:0]   o_slot
);

    localparam int AW        = $clog2(ALPHABET_SIZE);
    localparam int NUM_BYTES = 1 << ahc_pkg::BYTE_W;

    typedef logic [AW-1:0] t_slot_table [NUM_BYTES];

    // Every byte value maps to its slot; the table is fixed at elaboration.
    function automatic t_slot_table build_slot_table();
        t_slot_table tbl;
        for (int b = 0; b < NUM_BYTES; b++) begin
            tbl[b] = AW'(b % ALPHABET_SIZE);
        end
        return tbl;
    endfunction

    localparam t_slot_table SLOT_TABLE = build_slot_table();

    assign o_slot = SLOT_TABLE[i_byte];

endmodule

`default_nettype wire

### rtl/ahc_update.sv
// ----------------------------------------------------------------------------
// Counter update stage
// Read-modify-write of one balance per cycle, nonzero count and pair flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ahc_update #(
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ahc_pkg::t_op                        i_op,
    input  wire logic [$clog2(ALPHABET_SIZE)-1:0]    i_addr,
    input  wire logic [ahc_pkg::BALANCE_W-1:0]       i_rd_data,
    output logic                                     o_wr_en,
    output logic      [$clog2(ALPHABET_SIZE)-1:0]    o_wr_addr,
    output logic      [ahc_pkg::BALANCE_W-1:0]       o_wr_data,
    output logic                                     o_done,
    output ahc_pkg::t_out_word                       o_result
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int BW = ahc_pkg::BALANCE_W;
    localparam int CW = ahc_pkg::COUNT_W;

    logic [ALPHABET_SIZE-1:0] r_valid_bits;
    logic                     r_fw_valid;
    logic [AW-1:0]            r_fw_addr;
    logic [BW-1:0]            r_fw_data;
    logic [CW-1:0]            r_count;
    logic                     r_mismatch;
    logic                     r_seen;

    logic [BW-1:0] before_val;
    logic [BW-1:0] after_val;
    logic          act;
    logic [CW-1:0] n_count;
    logic          n_mismatch;
    logic          n_seen;

    // The write of the previous cycle is not yet visible in the read data.
    always_comb begin
        if (r_fw_valid && (r_fw_addr == i_addr)) begin
            before_val = r_fw_data;
        end else if (r_valid_bits[i_addr]) begin
            before_val = i_rd_data;
        end else begin
            before_val = '0;
        end
        after_val = i_op.up ? (before_val + BW'(1)) : (before_val - BW'(1));
        act       = i_op.valid && i_op.en;

        n_count = r_count;
        if (act && (before_val == '0) && (after_val != '0)) begin
            n_count = r_count + CW'(1);
        end else if (act && (before_val != '0) && (after_val == '0)) begin
            n_count = r_count - CW'(1);
        end

        n_mismatch = r_mismatch | (i_op.valid && i_op.tail && i_op.mismatch);
        n_seen     = r_seen     | (i_op.valid && i_op.tail && i_op.seen);
    end

    assign o_done                  = i_op.valid && i_op.tail && i_op.final_item;
    assign o_result.is_anagram     = n_seen && !n_mismatch && (n_count == '0);
    assign o_result.length_differs = n_mismatch;

    // The closing update needs no write since the whole store is cleared.
    assign o_wr_en   = act && !o_done;
    assign o_wr_addr = i_addr;
    assign o_wr_data = after_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_fw_valid   <= 1'b0;
            r_count      <= '0;
            r_mismatch   <= 1'b0;
            r_seen       <= 1'b0;
        end else if (o_done) begin
            r_valid_bits <= '0;
            r_fw_valid   <= 1'b0;
            r_count      <= '0;
            r_mismatch   <= 1'b0;
            r_seen       <= 1'b0;
        end else begin
            if (o_wr_en) begin
                r_valid_bits[i_addr] <= 1'b1;
            end
            r_fw_valid <= o_wr_en;
            r_count    <= n_count;
            r_mismatch <= n_mismatch;
            r_seen     <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= i_addr;
        r_fw_data <= after_val;
    end

endmodule

`default_nettype wire

### rtl/anagram_histogram_checker_top.sv
// ----------------------------------------------------------------------------
// Anagram histogram checker
// Streams two strings side by side and reports whether they are anagrams.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per accepted handshake: a byte of each
// string with its present flag, and a flag that marks the last word of the
// pair. The output channel carries one word per pair, produced only by the
// last word: the anagram verdict and whether the present flags disagreed.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// Each word makes two read-modify-write passes over the single balance
// memory, one per byte, so a new word is held off until the previous word
// has issued its second pass.
// The result word passes through the issue stage, the update stage and
// the output register. A last word is held off while a result word still
// waits or another last word is in flight; other words keep flowing while
// a result waits. After a result the store is cleared at once through
// per-entry valid bits, so no clearing pass is needed. Reset clears the
// same state and empties the pipeline; the memory needs no initialization.
// When the receiver stalls, the result word holds until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "anagram_histogram_checker_top_assert.svh"

module anagram_histogram_checker_top #(
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ahc_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ahc_pkg::t_out_word      o_out_word
);

    localparam int AW = $clog2(ALPHABET_SIZE);

    // Issue stage: the accepted word with its bytes already folded to slots.
    logic          r_iss_valid;
    logic          r_iss_tail;
    logic [AW-1:0] r_slot1;
    logic [AW-1:0] r_slot2;
    logic          r_p1;
    logic          r_p2;
    logic          r_final;

    // Update stage: the counter update whose read data arrives this cycle.
    ahc_pkg::t_op  r_op;
    logic [AW-1:0] r_op_addr;

    // Output register.
    logic               r_out_valid;
    ahc_pkg::t_out_word r_out_word;

    logic [AW-1:0]       w_fold1;
    logic [AW-1:0]       w_fold2;
    logic                w_acc;
    logic                w_final_busy;
    logic [AW-1:0]       w_rd_addr;
    ahc_pkg::t_op        n_op;
    logic [ahc_pkg::BALANCE_W-1:0] w_rd_data;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [ahc_pkg::BALANCE_W-1:0] w_wr_data;
    logic                w_done;
    ahc_pkg::t_out_word  w_result;

    ahc_fold #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_fold1 (
        .i_byte (i_in_word.first_byte),
        .o_slot (w_fold1)
    );

    ahc_fold #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_fold2 (
        .i_byte (i_in_word.second_byte),
        .o_slot (w_fold2)
    );

    // Only one pair may be closing at a time, and its result must find the
    // output register empty.
    assign w_final_busy = (r_iss_valid && r_final) || (r_op.valid && r_op.final_item);
    assign o_in_stall   = (r_iss_valid && !r_iss_tail)
                       || (i_in_word.final_item && (r_out_valid || w_final_busy));
    assign w_acc        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
            r_iss_tail  <= 1'b0;
        end else if (w_acc) begin
            r_iss_valid <= 1'b1;
            r_iss_tail  <= 1'b0;
        end else if (r_iss_valid && !r_iss_tail) begin
            r_iss_tail  <= 1'b1;
        end else begin
            r_iss_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_slot1 <= w_fold1;
            r_slot2 <= w_fold2;
            r_p1    <= i_in_word.first_present;
            r_p2    <= i_in_word.second_present;
            r_final <= i_in_word.final_item;
        end
    end

    // The first byte is counted up in the first cycle, the second byte down
    // in the next; the flag updates ride on the second one.
    assign w_rd_addr = r_iss_tail ? r_slot2 : r_slot1;

    always_comb begin
        n_op.valid      = r_iss_valid;
        n_op.en         = r_iss_tail ? r_p2 : r_p1;
        n_op.up         = !r_iss_tail;
        n_op.tail       = r_iss_tail;
        n_op.final_item = r_final;
        n_op.mismatch   = r_p1 ^ r_p2;
        n_op.seen       = r_p1 | r_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_addr <= w_rd_addr;
    end

    ahc_ram #(
        .WIDTH (ahc_pkg::BALANCE_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_balance_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_iss_valid),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ahc_update #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (r_op),
        .i_addr    (r_op_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_done    (w_done),
        .o_result  (w_result)
    );

    // The stall rule on last words guarantees the register is empty whenever
    // a result arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `AHC_ASSERT_IMP(a_final_latency, i_clk, i_rst_n, w_acc && i_in_word.final_item, ##3 w_done)
    `AHC_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, w_done, !r_out_valid)
    `AHC_ASSERT_NEXT(a_issue_tail, i_clk, i_rst_n, r_iss_valid && !r_iss_tail, r_iss_valid && r_iss_tail)

endmodule

`default_nettype wire
